### design/bptc_pkg.sv
// shared types and constants for the barometer compensation pipeline
// no dependencies; every design file but bptc_checker imports this package

package bptc_pkg;

  // number of register stages from input to output
  localparam int NSTG = 9;

  // calibration register indexes
  localparam logic [2:0] REG_C1 = 3'd0;
  localparam logic [2:0] REG_C2 = 3'd1;
  localparam logic [2:0] REG_C3 = 3'd2;
  localparam logic [2:0] REG_C4 = 3'd3;
  localparam logic [2:0] REG_C5 = 3'd4;
  localparam logic [2:0] REG_C6 = 3'd5;

  // temperature thresholds in 0.01 degree units
  localparam logic signed [19:0] TEMP_REF  = 20'sd2000;
  localparam logic signed [19:0] TEMP_COLD = 20'sd1500;

  // second-order coefficients
  localparam logic [41:0] OFF2_A_K  = 42'd61;
  localparam logic [41:0] OFF2_B_K  = 42'd15;

  typedef struct packed {
    logic [15:0] c1;
    logic [15:0] c2;
    logic [15:0] c3;
    logic [15:0] c4;
    logic [15:0] c5;
    logic [15:0] c6;
  } cal_t;

  // per-stage load enables from the pipeline control
  typedef struct packed {
    logic [NSTG-1:0] en;
  } pipe_ctrl_t;

  // first-order results
  typedef struct packed {
    logic signed [18:0] temp1;
    logic signed [35:0] off1;
    logic signed [34:0] sens1;
    logic        [17:0] t2;
    logic        [23:0] d1;
  } first_t;

  // fully compensated temperature, offset and sensitivity
  typedef struct packed {
    logic signed [19:0] temp;
    logic signed [39:0] off;
    logic signed [39:0] sens;
    logic        [23:0] d1;
  } second_t;

endpackage

### design/bptc_cfg_regs.sv
// calibration word registers written through the configuration channel
// depends on bptc_pkg

module bptc_cfg_regs
  import bptc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output cal_t        cal
);

  cal_t cal_r;
  cal_t cal_nxt;

  assign cfg_ready = 1'b1;
  assign cal       = cal_r;

  always_comb begin
    cal_nxt = cal_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_C1:  cal_nxt.c1 = cfg_data;
        REG_C2:  cal_nxt.c2 = cfg_data;
        REG_C3:  cal_nxt.c3 = cfg_data;
        REG_C4:  cal_nxt.c4 = cfg_data;
        REG_C5:  cal_nxt.c5 = cfg_data;
        REG_C6:  cal_nxt.c6 = cfg_data;
        default: cal_nxt = cal_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
    end else begin
      cal_r <= cal_nxt;
    end
  end

endmodule

### design/bptc_pipe_ctrl.sv
// valid bits and load enables for the compensation pipeline
// depends on bptc_pkg

module bptc_pipe_ctrl
  import bptc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  output logic       out_tvalid,
  input  logic       out_tready,
  output pipe_ctrl_t ctrl
);

  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] v_nxt;
  logic [NSTG-1:0] en;

  // a stage loads when it is empty or its successor loads too
  always_comb begin
    en[NSTG-1] = !v_r[NSTG-1] || out_tready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  always_comb begin
    v_nxt[0] = en[0] ? in_tvalid : v_r[0];
    for (int k = 1; k < NSTG; k++) begin
      v_nxt[k] = en[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_tready  = en[0];
  assign out_tvalid = v_r[NSTG-1];
  assign ctrl.en    = en;

endmodule

### design/bptc_first_order.sv
// stages 0 to 2: temperature difference, calibration products, first-order terms
// depends on bptc_pkg

module bptc_first_order
  import bptc_pkg::*;
(
  input  logic        clk,
  input  pipe_ctrl_t  ctrl,
  input  cal_t        cal,
  input  logic [23:0] raw_pressure,
  input  logic [23:0] raw_temperature,
  output first_t      fo
);

  logic signed [24:0] dt_r;
  logic        [23:0] d1_0_r;

  logic signed [41:0] m6_r;
  logic signed [41:0] m4_r;
  logic signed [41:0] m3_r;
  logic signed [49:0] dtsq_r;
  logic        [23:0] d1_1_r;

  first_t fo_r;
  first_t fo_nxt;

  // stage 0: dT = D2 - C5 * 256
  always_ff @(posedge clk) begin
    if (ctrl.en[0]) begin
      dt_r   <= $signed({1'b0, raw_temperature}) - $signed({1'b0, cal.c5, 8'b0});
      d1_0_r <= raw_pressure;
    end
  end

  // stage 1: four independent products of dT
  always_ff @(posedge clk) begin
    if (ctrl.en[1]) begin
      m6_r   <= 42'(dt_r) * 42'($signed({1'b0, cal.c6}));
      m4_r   <= 42'(dt_r) * 42'($signed({1'b0, cal.c4}));
      m3_r   <= 42'(dt_r) * 42'($signed({1'b0, cal.c3}));
      dtsq_r <= 50'(dt_r) * 50'(dt_r);
      d1_1_r <= d1_0_r;
    end
  end

  // stage 2: dropping low bits of a two's complement value is a flooring shift
  always_comb begin
    fo_nxt.temp1 = $signed(m6_r[41:23]) + 19'sd2000;
    fo_nxt.off1  = $signed({3'b000, cal.c2, 17'b0}) + $signed(m4_r[41:6]);
    fo_nxt.sens1 = $signed({3'b000, cal.c1, 16'b0}) + $signed(m3_r[41:7]);
    fo_nxt.t2    = dtsq_r[48:31];
    fo_nxt.d1    = d1_1_r;
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[2]) begin
      fo_r <= fo_nxt;
    end
  end

  assign fo = fo_r;

endmodule

### design/bptc_second_order.sv
// stages 3 to 5: low and very low temperature corrections
// depends on bptc_pkg

module bptc_second_order
  import bptc_pkg::*;
(
  input  logic       clk,
  input  pipe_ctrl_t ctrl,
  input  first_t     fo,
  output second_t    so
);

  logic signed [19:0] a_w;
  logic signed [19:0] b_w;
  logic signed [19:0] temp1_w;

  logic signed [39:0] asq_r;
  logic signed [39:0] bsq_r;
  logic               lt_ref_3_r;
  logic               lt_cold_3_r;
  first_t             fo_3_r;

  logic        [41:0] off2_w;
  logic        [41:0] sens2_w;
  logic        [39:0] off2_r;
  logic        [39:0] sens2_r;
  logic               lt_ref_4_r;
  first_t             fo_4_r;

  second_t so_r;
  second_t so_nxt;

  assign temp1_w = {fo.temp1[18], fo.temp1};
  assign a_w     = temp1_w - TEMP_REF;
  assign b_w     = temp1_w + TEMP_COLD;

  // stage 3: squares of the distances from both thresholds
  always_ff @(posedge clk) begin
    if (ctrl.en[3]) begin
      asq_r       <= 40'(a_w) * 40'(a_w);
      bsq_r       <= 40'(b_w) * 40'(b_w);
      lt_ref_3_r  <= temp1_w < TEMP_REF;
      lt_cold_3_r <= temp1_w < -TEMP_COLD;
      fo_3_r      <= fo;
    end
  end

  // stage 4: OFF2 and SENS2, both thresholds judged on first-order temperature
  always_comb begin
    off2_w  = '0;
    sens2_w = '0;
    if (lt_ref_3_r) begin
      off2_w  = ({6'b0, asq_r[35:0]} * OFF2_A_K) >> 4;
      sens2_w = {5'b0, asq_r[35:0], 1'b0};
      if (lt_cold_3_r) begin
        off2_w  = off2_w + {6'b0, bsq_r[35:0]} * OFF2_B_K;
        sens2_w = sens2_w + {3'b0, bsq_r[35:0], 3'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[4]) begin
      off2_r     <= off2_w[39:0];
      sens2_r    <= sens2_w[39:0];
      lt_ref_4_r <= lt_ref_3_r;
      fo_4_r     <= fo_3_r;
    end
  end

  // stage 5: apply corrections
  always_comb begin
    so_nxt.temp = {fo_4_r.temp1[18], fo_4_r.temp1}
                - (lt_ref_4_r ? $signed({2'b00, fo_4_r.t2}) : 20'sd0);
    so_nxt.off  = {{4{fo_4_r.off1[35]}}, fo_4_r.off1} - $signed(off2_r);
    so_nxt.sens = {{5{fo_4_r.sens1[34]}}, fo_4_r.sens1} - $signed(sens2_r);
    so_nxt.d1   = fo_4_r.d1;
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[5]) begin
      so_r <= so_nxt;
    end
  end

  assign so = so_r;

endmodule

### design/bptc_pressure.sv
// stages 6 to 8: D1 * SENS in two partial products, offset removal, output register
// depends on bptc_pkg

module bptc_pressure
  import bptc_pkg::*;
(
  input  logic               clk,
  input  pipe_ctrl_t         ctrl,
  input  second_t            so,
  output logic signed [19:0] temperature_centi,
  output logic signed [31:0] pressure_pa
);

  logic        [43:0] pp_lo_r;
  logic signed [44:0] pp_hi_r;
  logic signed [39:0] off_6_r;
  logic signed [19:0] temp_6_r;

  logic signed [63:0] prod_r;
  logic signed [39:0] off_7_r;
  logic signed [19:0] temp_7_r;

  logic signed [42:0] diff_w;
  logic signed [19:0] temp_8_r;
  logic signed [31:0] pres_8_r;

  // stage 6: low 20 bits of SENS unsigned, upper 20 bits signed
  always_ff @(posedge clk) begin
    if (ctrl.en[6]) begin
      pp_lo_r  <= 44'(so.d1) * 44'(so.sens[19:0]);
      pp_hi_r  <= 45'($signed({1'b0, so.d1})) * 45'($signed(so.sens[39:20]));
      off_6_r  <= so.off;
      temp_6_r <= so.temp;
    end
  end

  // stage 7: recombine, magnitude of D1 * SENS stays below 2^62
  always_ff @(posedge clk) begin
    if (ctrl.en[7]) begin
      prod_r   <= $signed({pp_hi_r[43:0], 20'b0}) + $signed({20'b0, pp_lo_r});
      off_7_r  <= off_6_r;
      temp_7_r <= temp_6_r;
    end
  end

  // stage 8: pressure stays within 28 signed bits and temperature within 20,
  // so no saturation is applied and sign extension suffices
  assign diff_w = $signed(prod_r[63:21]) - {{3{off_7_r[39]}}, off_7_r};

  always_ff @(posedge clk) begin
    if (ctrl.en[8]) begin
      pres_8_r <= {{4{diff_w[42]}}, diff_w[42:15]};
      temp_8_r <= temp_7_r;
    end
  end

  assign temperature_centi = temp_8_r;
  assign pressure_pa       = pres_8_r;

endmodule

### design/baro_pressure_temp_compensation.sv
// channel      dir  width  contents
// in_tdata     in   48     raw_pressure [23:0], raw_temperature [47:24]
// out_tdata    out  56     temperature_centi [19:0], pressure_pa [51:20], zero pad
// cfg          in   3+16   calibration word index, word value
//
// nine register stages; one transaction accepted per cycle unless a stalled output has filled every stage
// the depth is set by the split D1 * SENS product and the second-order squares
// reset clears the calibration words and every stage valid bit
// out_tready low stalls the last full stage, bubbles ahead of it still close up
// configuration writes are taken every cycle; cfg_ready is always high
//
// top level of the barometer compensation pipeline
// depends on bptc_pkg and the bptc_* stage modules

module baro_pressure_temp_compensation
  import bptc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // raw_pressure, raw_temperature
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // temperature_centi, pressure_pa, zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cal_t               cal;
  pipe_ctrl_t         ctrl;
  first_t             fo;
  second_t            so;
  logic signed [19:0] temperature_centi;
  logic signed [31:0] pressure_pa;

  bptc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cal       (cal)
  );

  bptc_pipe_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .ctrl       (ctrl)
  );

  bptc_first_order u_first (
    .clk             (clk),
    .ctrl            (ctrl),
    .cal             (cal),
    .raw_pressure    (in_tdata[23:0]),
    .raw_temperature (in_tdata[47:24]),
    .fo              (fo)
  );

  bptc_second_order u_second (
    .clk  (clk),
    .ctrl (ctrl),
    .fo   (fo),
    .so   (so)
  );

  bptc_pressure u_pres (
    .clk               (clk),
    .ctrl              (ctrl),
    .so                (so),
    .temperature_centi (temperature_centi),
    .pressure_pa       (pressure_pa)
  );

  assign out_tdata = {4'b0, pressure_pa, temperature_centi};

endmodule

### design/bptc_checker.sv
// port-level checks on the barometer compensation top level, with its bind
// depends only on the top level's ports

module bptc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic        cfg_ready
);

  // a held result keeps its data
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // pipeline is empty straight after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a free output lets every stage move, so the input is never held off
  a_no_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while output is free");

  // configuration writes are never held off
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("configuration channel not ready");

endmodule

bind baro_pressure_temp_compensation bptc_checker u_bptc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_ready  (cfg_ready)
);
